// ----- design/grc_pkg.sv -----
// Shared types, constants and a helper function of the grid raycast column block.
// Used by the datapath, controller and top modules and by the bench; depends on nothing else.
package grc_pkg;

    // Fixed point and map geometry
    localparam int FRAC_BITS = 16;
    localparam int MAP_SIZE  = 32;
    localparam int MAP_BITS  = $clog2(MAP_SIZE);
    localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int CELL_W    = 3;
    localparam int COORD_W   = MAP_BITS + 2;

    // Walk limit: two map widths plus two steps
    localparam int WALK_LIMIT = 2 * MAP_SIZE + 2;
    localparam int CNT_W      = 7;

    // Datapath widths
    localparam int POS_W   = 21;
    localparam int DIR_W   = 18;
    localparam int SCR_W   = 12;
    localparam int CAM_W   = 31;
    localparam int RAY_W   = 34;
    localparam int DIST_W  = 47;
    localparam int DIV_W   = 38;
    localparam int LINE_W  = 25;
    localparam int PROD_W  = DIR_W + RAY_W;
    localparam int DNUM_W  = 22;

    localparam logic [DIST_W-1:0] DIST_SAT = {1'b1, {(DIST_W-1){1'b0}}};
    localparam logic [LINE_W-1:0] LINE_CAP = {1'b1, {(LINE_W-1){1'b0}}};
    localparam logic [DIV_W-1:0]  STEP_NUM = DIV_W'(64'd1 << (2 * FRAC_BITS));

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;

    localparam logic [POS_W-1:0]        POS_X_RST  = 21'd1441792;
    localparam logic [POS_W-1:0]        POS_Y_RST  = 21'd786432;
    localparam logic signed [DIR_W-1:0] DIR_X_RST  = 18'sd65536;
    localparam logic signed [DIR_W-1:0] DIR_Y_RST  = 18'sd0;
    localparam logic [SCR_W-1:0]        WIDTH_RST  = 12'd1600;
    localparam logic [SCR_W-1:0]        HEIGHT_RST = 12'd1200;

    // Input item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [4:0]        cell_x;
        logic [4:0]        cell_y;
        logic [CELL_W-1:0] cell_value;
        logic [SCR_W-1:0]  column;
    } in_t;

    typedef struct packed {
        logic [SCR_W-1:0]  out_column;
        logic [SCR_W-1:0]  draw_start;
        logic [SCR_W-1:0]  draw_end;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
        logic              hit_side;
        logic [CELL_W-1:0] wall_value;
        logic              left_map;
    } out_t;

    typedef enum logic [2:0] {
        DIV_CAM,
        DIV_DX,
        DIV_DY,
        DIV_PERP,
        DIV_LINE
    } div_sel_t;

    typedef enum logic [1:0] {
        MUL_RX,
        MUL_RY,
        MUL_SX,
        MUL_SY
    } mul_sel_t;

    typedef struct packed {
        logic     clr;
        logic     cast_init;
        logic     wr_cell;
        logic     div_start;
        div_sel_t div_sel;
        mul_sel_t mul_sel;
        logic     mul_ld;
        logic     walk_step;
        logic     walk_check;
        logic     ld_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic clr_last;
        logic oob;
        logic cell_hit;
        logic walk_full;
    } dp_status_t;

    // Wall colour {red, green, blue} of a cell value
    function automatic logic [23:0] colour_of(input logic [CELL_W-1:0] v);
        logic [23:0] c;
        case (v)
            3'd1: c = 24'hFF0000;
            3'd2: c = 24'h00FF00;
            3'd3: c = 24'h0000FF;
            3'd4: c = 24'hFFFF00;
            default: c = 24'hFF00FF;
        endcase
        return c;
    endfunction

endpackage

// ----- design/grc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/grc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; no package needed.
module grc_div #(
    parameter int W = 38
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo,
    output logic         done
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, den_reg;
    logic [W:0]    rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    shifted, diff;

    assign shifted = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CW'(W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ----- design/grc_datapath.sv -----
// Datapath: configuration, map RAM, multiplier, shared divider, DDA walk and result register.
// Depends on grc_pkg, grc_ram and grc_div.
module grc_datapath import grc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_t                   s_data,
    input  logic                  in_load,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output out_t                  m_data
);

    // Configuration
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg;
    logic [SCR_W-1:0]        width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg  <= POS_X_RST;
            pos_y_reg  <= POS_Y_RST;
            dir_x_reg  <= DIR_X_RST;
            dir_y_reg  <= DIR_Y_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_POS_X:  pos_x_reg  <= cfg_data[POS_W-1:0];
                CFG_POS_Y:  pos_y_reg  <= cfg_data[POS_W-1:0];
                CFG_DIR_X:  dir_x_reg  <= $signed(cfg_data[DIR_W-1:0]);
                CFG_DIR_Y:  dir_y_reg  <= $signed(cfg_data[DIR_W-1:0]);
                CFG_WIDTH:  width_reg  <= cfg_data[SCR_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SCR_W-1:0];
                default: ;
            endcase
        end
    end

    // Latched input beat
    logic [SCR_W-1:0]  col_reg;
    logic [4:0]        cx_reg, cy_reg;
    logic [CELL_W-1:0] cv_reg;

    always_ff @(posedge aclk) begin
        if (in_load) begin
            col_reg <= s_data.column;
            cx_reg  <= s_data.cell_x;
            cy_reg  <= s_data.cell_y;
            cv_reg  <= s_data.cell_value;
        end
    end

    // Ray and walk state
    logic signed [CAM_W-1:0]   cam_reg;
    logic signed [RAY_W-1:0]   rx_reg, ry_reg;
    logic [DIST_W-1:0]         dx_reg, dy_reg, sx_reg, sy_reg;
    logic signed [COORD_W-1:0] mx_reg, my_reg;
    logic                      side_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CELL_W-1:0]         hit_val_reg;
    logic [DIV_W-1:0]          perp_reg;
    logic [LINE_W-1:0]         line_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [MAP_AW-1:0]         clr_addr_reg;

    logic [RAY_W-1:0] rx_mag, ry_mag;
    assign rx_mag = rx_reg[RAY_W-1] ? (~rx_reg + 1'b1) : rx_reg;
    assign ry_mag = ry_reg[RAY_W-1] ? (~ry_reg + 1'b1) : ry_reg;

    // Distance to the first cell border
    logic [FRAC_BITS:0] fxp_x, fxp_y;
    assign fxp_x = rx_reg[RAY_W-1] ? {1'b0, pos_x_reg[FRAC_BITS-1:0]}
                                   : 17'h10000 - {1'b0, pos_x_reg[FRAC_BITS-1:0]};
    assign fxp_y = ry_reg[RAY_W-1] ? {1'b0, pos_y_reg[FRAC_BITS-1:0]}
                                   : 17'h10000 - {1'b0, pos_y_reg[FRAC_BITS-1:0]};

    // Shared multiplier
    logic signed [DIR_W-1:0] mul_a;
    logic signed [RAY_W-1:0] mul_b;
    logic signed [RAY_W-1:0] cam_ext;
    assign cam_ext = {{(RAY_W-CAM_W){cam_reg[CAM_W-1]}}, cam_reg};

    always_comb begin
        case (cmd.mul_sel)
            MUL_RX: begin
                mul_a = dir_y_reg;
                mul_b = cam_ext;
            end
            MUL_RY: begin
                mul_a = dir_x_reg;
                mul_b = cam_ext;
            end
            MUL_SX: begin
                mul_a = $signed({1'b0, fxp_x});
                mul_b = $signed({1'b0, dx_reg[32:0]});
            end
            default: begin
                mul_a = $signed({1'b0, fxp_y});
                mul_b = $signed({1'b0, dy_reg[32:0]});
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    logic signed [RAY_W-1:0] prod_fl;
    assign prod_fl = $signed(prod_reg[RAY_W+FRAC_BITS-1:FRAC_BITS]);

    // Wall distance numerator on the hit side
    logic signed [COORD_W-1:0] coord;
    logic [POS_W-1:0]          posv;
    logic                      neg_dir;
    logic signed [DNUM_W:0]    dnum_s;
    logic [DNUM_W-1:0]         dnum;
    logic [RAY_W-1:0]          den_sel;
    logic                      den_zero;

    assign coord    = side_reg ? my_reg : mx_reg;
    assign posv     = side_reg ? pos_y_reg : pos_x_reg;
    assign neg_dir  = side_reg ? ry_reg[RAY_W-1] : rx_reg[RAY_W-1];
    assign dnum_s   = $signed({2'b00, coord[MAP_BITS-1:0], {FRAC_BITS{1'b0}}})
                    - $signed({2'b00, posv})
                    + (neg_dir ? 23'sd65536 : 23'sd0);
    assign dnum     = dnum_s[DNUM_W] ? DNUM_W'(~dnum_s + 1'b1) : dnum_s[DNUM_W-1:0];
    assign den_sel  = side_reg ? ry_mag : rx_mag;
    assign den_zero = (den_sel == '0);

    // Shared divider
    logic [DIV_W-1:0] div_num, div_den, div_quo;
    logic             div_done;
    logic [SCR_W-1:0] w_eff;
    assign w_eff = (width_reg == '0) ? SCR_W'(1) : width_reg;

    always_comb begin
        case (cmd.div_sel)
            DIV_CAM: begin
                div_num = {9'b0, col_reg, {(FRAC_BITS+1){1'b0}}};
                div_den = {26'b0, w_eff};
            end
            DIV_DX: begin
                div_num = STEP_NUM;
                div_den = {4'b0, rx_mag};
            end
            DIV_DY: begin
                div_num = STEP_NUM;
                div_den = {4'b0, ry_mag};
            end
            DIV_PERP: begin
                div_num = {dnum, {FRAC_BITS{1'b0}}};
                div_den = {4'b0, den_sel};
            end
            default: begin
                div_num = {10'b0, height_reg, {FRAC_BITS{1'b0}}};
                div_den = perp_reg;
            end
        endcase
    end

    grc_div #(.W(DIV_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .done    (div_done)
    );

    // DDA step
    logic                      sx_lt;
    logic [DIST_W:0]           sx_sum, sy_sum;
    logic [DIST_W-1:0]         sx_add, sy_add;
    logic signed [COORD_W-1:0] mx_n, my_n;

    assign sx_lt  = sx_reg < sy_reg;
    assign sx_sum = {1'b0, sx_reg} + {1'b0, dx_reg};
    assign sy_sum = {1'b0, sy_reg} + {1'b0, dy_reg};
    assign sx_add = (sx_sum > {1'b0, DIST_SAT}) ? DIST_SAT : sx_sum[DIST_W-1:0];
    assign sy_add = (sy_sum > {1'b0, DIST_SAT}) ? DIST_SAT : sy_sum[DIST_W-1:0];
    assign mx_n   = sx_lt ? mx_reg + (rx_reg[RAY_W-1] ? -7'sd1 : 7'sd1) : mx_reg;
    assign my_n   = sx_lt ? my_reg : my_reg + (ry_reg[RAY_W-1] ? -7'sd1 : 7'sd1);

    function automatic logic in_map(input logic signed [COORD_W-1:0] v);
        return (v >= 7'sd0) && (v < $signed(COORD_W'(MAP_SIZE)));
    endfunction

    // Map RAM
    logic              ram_we;
    logic [MAP_AW-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    assign ram_we    = cmd.clr | cmd.wr_cell;
    assign ram_waddr = cmd.clr ? clr_addr_reg : {cy_reg, cx_reg};
    assign ram_wdata = cmd.clr ? '0 : cv_reg;
    assign ram_raddr = {my_n[MAP_BITS-1:0], mx_n[MAP_BITS-1:0]};

    grc_ram #(.WIDTH(CELL_W), .DEPTH(MAP_DEPTH)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign status.div_done  = div_done;
    assign status.clr_last  = (clr_addr_reg == '1);
    assign status.oob       = !(in_map(mx_reg) && in_map(my_reg));
    assign status.cell_hit  = !status.oob && (ram_rdata != '0);
    assign status.walk_full = (cnt_reg == CNT_W'(WALK_LIMIT));

    // Ray, step and walk registers
    always_ff @(posedge aclk) begin
        if (div_done) begin
            case (cmd.div_sel)
                DIV_CAM:  cam_reg <= $signed({1'b0, div_quo[CAM_W-2:0]}) - 31'sd65536;
                DIV_DX:   dx_reg  <= (rx_mag == '0) ? DIST_SAT : {14'b0, div_quo[32:0]};
                DIV_DY:   dy_reg  <= (ry_mag == '0) ? DIST_SAT : {14'b0, div_quo[32:0]};
                DIV_PERP: perp_reg <= div_quo;
                default: begin
                    if (den_zero) begin
                        line_reg <= '0;
                    end else if (perp_reg == '0 || div_quo > {13'b0, LINE_CAP}) begin
                        line_reg <= LINE_CAP;
                    end else begin
                        line_reg <= div_quo[LINE_W-1:0];
                    end
                end
            endcase
        end

        if (cmd.mul_ld) begin
            case (cmd.mul_sel)
                MUL_RX: rx_reg <= {{(RAY_W-DIR_W){dir_x_reg[DIR_W-1]}}, dir_x_reg} + prod_fl;
                MUL_RY: ry_reg <= {{(RAY_W-DIR_W){dir_y_reg[DIR_W-1]}}, dir_y_reg} - prod_fl;
                MUL_SX: sx_reg <= dx_reg[DIST_W-1] ? {fxp_x, 30'b0}
                                                   : {14'b0, prod_reg[48:FRAC_BITS]};
                default: sy_reg <= dy_reg[DIST_W-1] ? {fxp_y, 30'b0}
                                                    : {14'b0, prod_reg[48:FRAC_BITS]};
            endcase
        end

        if (cmd.cast_init) begin
            mx_reg   <= $signed({2'b00, pos_x_reg[POS_W-1:FRAC_BITS]});
            my_reg   <= $signed({2'b00, pos_y_reg[POS_W-1:FRAC_BITS]});
            side_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.walk_step) begin
            cnt_reg <= cnt_reg + 1'b1;
            mx_reg  <= mx_n;
            my_reg  <= my_n;
            if (sx_lt) begin
                sx_reg   <= sx_add;
                side_reg <= 1'b0;
            end else begin
                sy_reg   <= sy_add;
                side_reg <= 1'b1;
            end
        end

        if (cmd.walk_check) begin
            hit_val_reg <= status.oob ? '0 : ram_rdata;
        end
    end

    // Wall span and colour
    logic              left;
    logic [10:0]       half;
    logic [LINE_W-2:0] hl;
    logic [LINE_W-1:0] end_sum;
    logic [SCR_W-1:0]  span_start, span_end;
    logic [23:0]       rgb;

    assign left    = (hit_val_reg == '0);
    assign half    = height_reg[SCR_W-1:1];
    assign hl      = line_reg[LINE_W-1:1];
    assign end_sum = {1'b0, hl} + {14'b0, half};
    assign rgb     = colour_of(hit_val_reg);

    always_comb begin
        if (height_reg == '0) begin
            span_start = '0;
            span_end   = '0;
        end else begin
            span_start = (hl >= {13'b0, half}) ? '0 : {1'b0, half - hl[10:0]};
            span_end   = (end_sum >= {13'b0, height_reg}) ? height_reg - 1'b1
                                                          : end_sum[SCR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            m_data.out_column <= col_reg;
            m_data.alpha      <= 8'hFF;
            m_data.wall_value <= hit_val_reg;
            m_data.left_map   <= left;
            if (left) begin
                m_data.draw_start <= '0;
                m_data.draw_end   <= '0;
                m_data.red        <= '0;
                m_data.green      <= '0;
                m_data.blue       <= '0;
                m_data.hit_side   <= 1'b0;
            end else begin
                m_data.draw_start <= span_start;
                m_data.draw_end   <= span_end;
                m_data.hit_side   <= side_reg;
                m_data.red        <= side_reg ? {1'b0, rgb[23:17]} : rgb[23:16];
                m_data.green      <= side_reg ? {1'b0, rgb[15:9]}  : rgb[15:8];
                m_data.blue       <= side_reg ? {1'b0, rgb[7:1]}   : rgb[7:0];
            end
        end
    end

endmodule

// ----- design/grc_ctrl.sv -----
// Controller state machine: sequences map clear, cell writes and the cast steps.
// Depends on grc_pkg.
module grc_ctrl import grc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_cast,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       in_load,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_CAM,
        S_RX_MUL, S_RX_LD, S_RY_MUL, S_RY_LD,
        S_DX, S_DY, S_SX_MUL, S_SX_LD, S_SY_MUL, S_SY_LD,
        S_STEP, S_CHECK, S_PERP, S_LINE, S_FINISH
    } state_t;

    state_t  state_reg, state_next;
    dp_cmd_t cmd_reg, cmd_next;
    logic    m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign in_load = s_valid & s_ready;
    assign m_valid = m_valid_reg;

    // sweep the map while in the clear state
    always_comb begin
        cmd     = cmd_reg;
        cmd.clr = (state_reg == S_CLEAR);
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        m_valid_next = m_valid_reg;

        // pulses last one cycle; selects hold
        cmd_next.clr        = 1'b0;
        cmd_next.cast_init  = 1'b0;
        cmd_next.wr_cell    = 1'b0;
        cmd_next.div_start  = 1'b0;
        cmd_next.mul_ld     = 1'b0;
        cmd_next.walk_step  = 1'b0;
        cmd_next.walk_check = 1'b0;
        cmd_next.ld_out     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd_reg.ld_out) begin
            m_valid_next = 1'b1;
        end

        case (state_reg)
            S_CLEAR: begin
                if (status.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_cast == CMD_CAST) begin
                        cmd_next.div_start = 1'b1;
                        cmd_next.div_sel   = DIV_CAM;
                        cmd_next.cast_init = 1'b1;
                        state_next         = S_CAM;
                    end else begin
                        cmd_next.wr_cell = 1'b1;
                        state_next       = S_WRITE;
                    end
                end
            end
            S_WRITE: state_next = S_IDLE;
            S_CAM: begin
                if (status.div_done) begin
                    cmd_next.mul_sel = MUL_RX;
                    state_next       = S_RX_MUL;
                end
            end
            S_RX_MUL: begin
                cmd_next.mul_ld = 1'b1;
                state_next      = S_RX_LD;
            end
            S_RX_LD: begin
                cmd_next.mul_sel = MUL_RY;
                state_next       = S_RY_MUL;
            end
            S_RY_MUL: begin
                cmd_next.mul_ld = 1'b1;
                state_next      = S_RY_LD;
            end
            S_RY_LD: begin
                cmd_next.div_start = 1'b1;
                cmd_next.div_sel   = DIV_DX;
                state_next         = S_DX;
            end
            S_DX: begin
                if (status.div_done) begin
                    cmd_next.div_start = 1'b1;
                    cmd_next.div_sel   = DIV_DY;
                    state_next         = S_DY;
                end
            end
            S_DY: begin
                if (status.div_done) begin
                    cmd_next.mul_sel = MUL_SX;
                    state_next       = S_SX_MUL;
                end
            end
            S_SX_MUL: begin
                cmd_next.mul_ld = 1'b1;
                state_next      = S_SX_LD;
            end
            S_SX_LD: begin
                cmd_next.mul_sel = MUL_SY;
                state_next       = S_SY_MUL;
            end
            S_SY_MUL: begin
                cmd_next.mul_ld = 1'b1;
                state_next      = S_SY_LD;
            end
            S_SY_LD: begin
                cmd_next.walk_step = 1'b1;
                state_next         = S_STEP;
            end
            S_STEP: begin
                cmd_next.walk_check = 1'b1;
                state_next          = S_CHECK;
            end
            S_CHECK: begin
                if (status.cell_hit) begin
                    cmd_next.div_start = 1'b1;
                    cmd_next.div_sel   = DIV_PERP;
                    state_next         = S_PERP;
                end else if (status.oob || status.walk_full) begin
                    state_next = S_FINISH;
                end else begin
                    cmd_next.walk_step = 1'b1;
                    state_next         = S_STEP;
                end
            end
            S_PERP: begin
                if (status.div_done) begin
                    cmd_next.div_start = 1'b1;
                    cmd_next.div_sel   = DIV_LINE;
                    state_next         = S_LINE;
                end
            end
            S_LINE: begin
                if (status.div_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd_next.ld_out = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cmd_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- design/grid_raycast_column.sv -----
// Grid raycaster for one screen column: a write beat stores a map cell, a cast beat returns a span.
// A cast runs five divisions on a wall hit and three otherwise, on the one-bit-per-cycle
// divider, and walks up to 66 DDA steps.
// Throughput: one beat at a time; a finished result waits in the output register.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every cell of the map
// with s_ready low, while configuration writes are still taken.
module grid_raycast_column import grc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_load;

    // Controller: clear sweep, write and cast sequencing, output handshake
    grc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cast  (s_data.cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .in_load (in_load),
        .cmd     (cmd),
        .status  (status)
    );

    // Datapath: configuration, map, camera and DDA arithmetic, result register
    grc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .in_load   (in_load),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

// ----- bench/grid_raycast_column_test.sv -----
// Self-checking bench for grid_raycast_column: map writes and column casts checked against
// a bit-exact fixed-point raycaster model. Depends on grc_pkg and the grid_raycast_column RTL.
module grid_raycast_column_test;
    import grc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;

    grid_raycast_column DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // Shadow copy of the block's map and view registers
    logic [CELL_W-1:0]  grid [MAP_DEPTH];
    logic [POS_W-1:0]   view_x, view_y;
    logic signed [DIR_W-1:0] look_x, look_y;
    logic [SCR_W-1:0]   scr_w, scr_h;

    out_t spans_due [$];
    int   mismatches = 0;
    bit   quiet = 1'b0;     // set for the final stretch: no gaps, no stalls
    int   stall_left = 0;
    int   idle_cycles = 0;

    localparam longint ONE_Q = 64'd1 << FRAC_BITS;
    localparam longint unsigned SAT_Q = 64'd1 << (62 - FRAC_BITS);
    localparam longint unsigned CAP_Q = 64'd1 << 24;
    localparam int WATCHDOG = 6000;

    function automatic longint unsigned abs_q(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // Cell-to-cell distance along one axis, saturating for a zero or tiny component
    function automatic longint unsigned cell_stride(longint r);
        longint unsigned a, d;
        a = abs_q(r);
        if (a == 0) return SAT_Q;
        d = (64'd1 << (2 * FRAC_BITS)) / a;
        return d > SAT_Q ? SAT_Q : d;
    endfunction

    function automatic out_t cast_column(logic [SCR_W-1:0] col);
        out_t o;
        longint unsigned w, dx, dy, sx, sy, fx, fy, num, den, perp, line, h, half, hl;
        longint cam, rx, ry, mx, my, stx, sty;
        int side, value;
        bit left;
        logic [23:0] rgb;
        side = 0; value = 0; left = 1'b1; line = 0;
        w = scr_w != 0 ? scr_w : 1;
        h = scr_h;
        cam = longint'((longint'(col) << (FRAC_BITS + 1)) / w) - ONE_Q;
        rx = longint'(look_x) + ((longint'(look_y) * cam) >>> FRAC_BITS);
        ry = longint'(look_y) - ((longint'(look_x) * cam) >>> FRAC_BITS);
        dx = cell_stride(rx);
        dy = cell_stride(ry);
        mx = view_x >> FRAC_BITS;
        my = view_y >> FRAC_BITS;
        fx = view_x & (ONE_Q - 1);
        fy = view_y & (ONE_Q - 1);
        stx = rx < 0 ? -1 : 1;
        sty = ry < 0 ? -1 : 1;
        sx = ((rx < 0 ? fx : ONE_Q - fx) * dx) >> FRAC_BITS;
        sy = ((ry < 0 ? fy : ONE_Q - fy) * dy) >> FRAC_BITS;
        if (sx > SAT_Q) sx = SAT_Q;
        if (sy > SAT_Q) sy = SAT_Q;
        if (mx < MAP_SIZE && my < MAP_SIZE) begin
            for (int n = 0; n < WALK_LIMIT; n++) begin
                if (sx < sy) begin
                    sx = (sx + dx > SAT_Q) ? SAT_Q : sx + dx;
                    mx += stx;
                    side = 0;
                end else begin
                    sy = (sy + dy > SAT_Q) ? SAT_Q : sy + dy;
                    my += sty;
                    side = 1;
                end
                if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE) break;
                if (grid[my * MAP_SIZE + mx] != 0) begin
                    value = grid[my * MAP_SIZE + mx];
                    left = 1'b0;
                    break;
                end
            end
        end
        o = '0;
        o.out_column = col;
        o.alpha = 8'hFF;
        if (!left) begin
            if (side == 0) begin
                num = abs_q((mx << FRAC_BITS) - longint'(view_x) + (stx < 0 ? ONE_Q : 0));
                den = abs_q(rx);
            end else begin
                num = abs_q((my << FRAC_BITS) - longint'(view_y) + (sty < 0 ? ONE_Q : 0));
                den = abs_q(ry);
            end
            if (den != 0) begin
                perp = (num << FRAC_BITS) / den;
                line = perp == 0 ? CAP_Q : (h << FRAC_BITS) / perp;
                if (line > CAP_Q) line = CAP_Q;
            end
            half = h / 2;
            hl = line / 2;
            if (h != 0) begin
                o.draw_start = SCR_W'(hl >= half ? 0 : half - hl);
                o.draw_end = SCR_W'((hl + half >= h) ? h - 1 : hl + half);
            end
            case (value)
                1: rgb = 24'hFF0000;
                2: rgb = 24'h00FF00;
                3: rgb = 24'h0000FF;
                4: rgb = 24'hFFFF00;
                default: rgb = 24'hFF00FF;
            endcase
            o.red = rgb[23:16];
            o.green = rgb[15:8];
            o.blue = rgb[7:0];
            if (side == 1) begin
                o.red = o.red >> 1;
                o.green = o.green >> 1;
                o.blue = o.blue >> 1;
            end
            o.hit_side = side[0];
            o.wall_value = CELL_W'(value);
        end
        o.left_map = left;
        return o;
    endfunction

    // Send one beat; update the map shadow or queue the expected span on acceptance
    task automatic send_beat(in_t item);
        int gap;
        gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(19, 1) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        if (item.cmd == CMD_WRITE)
            grid[item.cell_y * MAP_SIZE + item.cell_x] = item.cell_value;
        else
            spans_due.push_back(cast_column(item.column));
    endtask

    task automatic put_cell(int x, int y, int v);
        in_t it;
        it = '0;
        it.cmd = CMD_WRITE;
        it.cell_x = 5'(x);
        it.cell_y = 5'(y);
        it.cell_value = CELL_W'(v);
        it.column = 12'($urandom);
        send_beat(it);
    endtask

    task automatic cast(int col);
        in_t it;
        it = in_t'($urandom);
        it.cmd = CMD_CAST;
        it.column = SCR_W'(col);
        send_beat(it);
    endtask

    // Wait for every span, then let any trailing map write settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (spans_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // Write all six view registers back to back; call only while idle
    task automatic set_view(int px, int py, int dxv, int dyv, int w, int h);
        int vals [6];
        vals = '{px, py, dxv, dyv, w, h};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= CFG_DATA_W'(vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        view_x = POS_W'(px);
        view_y = POS_W'(py);
        look_x = DIR_W'(dxv);
        look_y = DIR_W'(dyv);
        scr_w = SCR_W'(w);
        scr_h = SCR_W'(h);
    endtask

    task automatic clear_map();
        for (int i = 0; i < MAP_DEPTH; i++)
            if (grid[i] != 0) put_cell(i % MAP_SIZE, i / MAP_SIZE, 0);
    endtask

    // Empty map with reset view: every ray leaves the map, the center one with a zero y
    task automatic test_empty_map();
        cast(0);
        cast(800);
        cast(1599);
        cast(4095);
        drain();
    endtask

    // Walls seen from the reset view, every wall value, and the degenerate rays
    task automatic test_walls();
        for (int v = 1; v < 8; v++) put_cell(25, 12 + v - 4, v);
        put_cell(31, 31, 7);
        put_cell(0, 0, 0);
        cast(800);
        cast(0);
        cast(1599);
        cast(100);
        drain();
        // Standing on a cell edge facing the wall next to it: zero distance, full column
        set_view(5 << 16, (12 << 16) + 32768, -65536, 0, 1600, 1200);
        put_cell(4, 12, 2);
        cast(800);
        drain();
        // Zero direction: the walk only steps in y and hits with no y component
        set_view(22 << 16, 12 << 16, 0, 0, 1600, 1200);
        put_cell(22, 13, 3);
        cast(800);
        drain();
    endtask

    // Screen size extremes: width zero, height zero, columns far past the width
    task automatic test_screen_limits();
        set_view(1441792, 786432, 65536, 0, 0, 0);
        cast(0);
        cast(4095);
        drain();
        set_view(1441792, 786432, -65536, 65536, 1, 4095);
        cast(0);
        cast(1);
        cast(4095);
        drain();
        set_view(2097151, 0, 65536, -65536, 4095, 1);
        cast(0);
        cast(2047);
        cast(4094);
        drain();
    endtask

    // Random views over random maps: mostly casts; a border ring walls the map in some phases, others stay sparse
    task automatic test_random(int phases, int beats);
        int px, py, w;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(5))
                0: px = 0;
                1: px = 2097151;
                default: px = $urandom_range(2097151);
            endcase
            py = ($urandom_range(4) == 0) ? 2097151 * $urandom_range(1) :
                 $urandom_range(2097151);
            w = ($urandom_range(4) == 0) ? 4095 * $urandom_range(1) : $urandom_range(4095);
            set_view(px, py,
                     ($urandom_range(5) == 0) ? 65536 - 131072 * $urandom_range(1) :
                         $urandom_range(131072) - 65536,
                     ($urandom_range(5) == 0) ? -65536 : $urandom_range(131072) - 65536,
                     w, ($urandom_range(4) == 0) ? 4095 * $urandom_range(1) :
                         $urandom_range(4095));
            if ($urandom_range(1)) begin
                // Border ring keeps most rays on the map
                for (int i = 0; i < MAP_SIZE; i++) begin
                    put_cell(i, 0, $urandom_range(7, 1));
                    put_cell(i, 31, $urandom_range(7, 1));
                    put_cell(0, i, $urandom_range(7, 1));
                    put_cell(31, i, $urandom_range(7, 1));
                end
            end
            for (int i = 0; i < beats; i++) begin
                if ($urandom_range(2) == 0)
                    put_cell($urandom_range(31), $urandom_range(31),
                             ($urandom_range(3) == 0) ? 0 : $urandom_range(7));
                else
                    cast(($urandom_range(4) == 0 || w == 0) ? $urandom_range(4095) :
                         $urandom_range(w - 1));
            end
            drain();
            if ($urandom_range(2) == 0) clear_map();
            drain();
        end
    endtask

    initial begin
        for (int i = 0; i < MAP_DEPTH; i++) grid[i] = '0;
        view_x = POS_X_RST;
        view_y = POS_Y_RST;
        look_x = DIR_X_RST;
        look_y = DIR_Y_RST;
        scr_w = WIDTH_RST;
        scr_h = HEIGHT_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_map();
        test_walls();
        test_screen_limits();
        test_random(3, 50);
        quiet = 1'b1;
        test_random(1, 40);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random stall bursts until the quiet stretch
    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(5) == 0) begin
            stall_left <= $urandom_range(19, 1) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check each accepted span against the oldest expectation
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (spans_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected span: %p", m_data);
            end else begin
                want = spans_due.pop_front();
                if (m_data.out_column !== want.out_column || m_data.draw_start !== want.draw_start
                    || m_data.draw_end !== want.draw_end || m_data.red !== want.red
                    || m_data.green !== want.green || m_data.blue !== want.blue
                    || m_data.alpha !== want.alpha || m_data.hit_side !== want.hit_side
                    || m_data.wall_value !== want.wall_value
                    || m_data.left_map !== want.left_map) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("span mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    // Hang detection: too long without any beat moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- sim.f -----
design/grc_pkg.sv
design/grc_ram.sv
design/grc_div.sv
design/grc_datapath.sv
design/grc_ctrl.sv
design/grid_raycast_column.sv
bench/grid_raycast_column_test.sv
